[src/coin_change_way_counter_top_assert.svh]
// Assertion macros for the coin change way counter checker.
`ifndef COIN_CHANGE_WAY_COUNTER_TOP_ASSERT_SVH
`define COIN_CHANGE_WAY_COUNTER_TOP_ASSERT_SVH

// Check a property on every rising clock edge outside of reset.
`define CCWC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error("ccwc: property failed");

// Check a property on every rising clock edge, reset included.
`define CCWC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
    else $error("ccwc: property failed");

`endif

[src/ccwc_pkg.sv]
// Widths of the stream and configuration fields of the coin change way counter.
package ccwc_pkg;

    localparam int COIN_W     = 10;
    localparam int TARGET_W   = 10;
    localparam int IN_TDATA_W = 16;
    localparam int WAY_W      = 32;
    localparam int OUT_USER_W = 1;

endpackage

[src/coin_change_way_counter_top.sv]
// Coin change way counter: sequencer and saturating adder over the ways table.
// A coin sweeps the table one entry per cycle from the coin value up to the target,
// then passes through a drain state. A zero coin or one above the target skips the
// sweep; the last coin adds readout (held while the previous result waits) and then
// a clearing pass over all MAX_AMOUNT + 1 entries before the next coin.
// Reset (synchronous, active low) starts the same clearing pass; the port takes no
// coin until it ends. The single memory write port sets the one-entry-per-cycle pace.
module coin_change_way_counter_top #(
    parameter int MAX_AMOUNT  = 1023,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: target_amount
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ccwc_pkg::TARGET_W-1:0]  i_cfg_data,
    // input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [ccwc_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,  // [9:0] coin_value
    input  logic                           i_s_axis_tlast,   // last_coin
    // output stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [ccwc_pkg::WAY_W-1:0]     o_m_axis_tdata,   // [31:0] way_count
    output logic [ccwc_pkg::OUT_USER_W-1:0] o_m_axis_tuser   // [0] saturated
);

    localparam int AW = (MAX_AMOUNT > 1) ? $clog2(MAX_AMOUNT + 1) : 1;
    localparam int XW = (AW > ccwc_pkg::TARGET_W) ? AW : ccwc_pkg::TARGET_W;
    localparam int CW = COUNT_WIDTH;
    localparam int DW = COUNT_WIDTH + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_RD,
        S_CAP
    } t_state;

    t_state                      r_state;
    logic [ccwc_pkg::TARGET_W-1:0] r_target;
    logic [AW-1:0]               r_j;
    logic [AW-1:0]               r_coin;
    logic [AW-1:0]               r_tgt;
    logic                        r_last;
    logic                        r_p_vld;
    logic [AW-1:0]               r_p_addr;
    logic                        r_fwd;
    logic [CW-1:0]               r_last_cnt;
    logic                        r_last_sat;
    logic                        r_o_valid;
    logic [ccwc_pkg::WAY_W-1:0]  r_o_way;
    logic                        r_o_sat;

    logic [XW-1:0]  w_tgt_x;
    logic [XW-1:0]  w_eff_x;
    logic [XW-1:0]  w_coin_x;
    logic           w_skip;
    logic           w_in_acc;
    logic           w_out_free;
    logic [AW-1:0]  w_raddr_a;
    logic [AW-1:0]  w_raddr_b;
    logic [DW-1:0]  w_rdata_a;
    logic [DW-1:0]  w_rdata_b;
    logic [CW-1:0]  w_a_cnt;
    logic           w_a_sat;
    logic [CW-1:0]  w_b_cnt;
    logic           w_b_sat;
    logic [CW:0]    w_sum;
    logic [CW-1:0]  w_add_cnt;
    logic           w_add_sat;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [DW-1:0]  w_wdata;
    logic [63:0]    w_cnt64;
    logic           w_over;

    assign w_tgt_x  = XW'(r_target);
    assign w_eff_x  = (w_tgt_x > XW'(MAX_AMOUNT)) ? XW'(MAX_AMOUNT) : w_tgt_x;
    assign w_coin_x = XW'(i_s_axis_tdata[ccwc_pkg::COIN_W-1:0]);
    assign w_skip   = (w_coin_x == '0) || (w_coin_x > w_eff_x);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_o_valid || i_m_axis_tready;

    assign w_raddr_a = ((r_state == S_RD) || (r_state == S_CAP)) ? r_tgt : r_j;
    assign w_raddr_b = r_j - r_coin;

    assign w_a_cnt   = w_rdata_a[CW-1:0];
    assign w_a_sat   = w_rdata_a[CW];
    assign w_b_cnt   = r_fwd ? r_last_cnt : w_rdata_b[CW-1:0];
    assign w_b_sat   = r_fwd ? r_last_sat : w_rdata_b[CW];
    assign w_sum     = {1'b0, w_a_cnt} + {1'b0, w_b_cnt};
    assign w_add_cnt = w_sum[CW] ? {CW{1'b1}} : w_sum[CW-1:0];
    assign w_add_sat = w_a_sat | w_b_sat | w_sum[CW];

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_j;
            w_wdata = {1'b0, (r_j == '0) ? CW'(1) : CW'(0)};
        end else begin
            w_we    = r_p_vld;
            w_waddr = r_p_addr;
            w_wdata = {w_add_sat, w_add_cnt};
        end
    end

    assign w_cnt64 = 64'(w_a_cnt);
    assign w_over  = |w_cnt64[63:32];

    ccwc_table #(
        .DEPTH (MAX_AMOUNT + 1),
        .AW    (AW),
        .DW    (DW)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
        end else if (i_cfg_valid) begin
            r_target  <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_j       <= '0;
            r_p_vld   <= 1'b0;
            r_fwd     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_p_vld <= (r_state == S_SWEEP);
            r_fwd   <= r_p_vld && (w_raddr_b == r_p_addr);
            if (r_state == S_SWEEP) begin
                r_p_addr <= r_j;
            end
            if (r_p_vld) begin
                r_last_cnt <= w_add_cnt;
                r_last_sat <= w_add_sat;
            end
            if (r_o_valid && i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_j == AW'(MAX_AMOUNT)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_coin <= w_coin_x[AW-1:0];
                        r_j    <= w_coin_x[AW-1:0];
                        r_tgt  <= w_eff_x[AW-1:0];
                        r_last <= i_s_axis_tlast;
                        if (!w_skip) begin
                            r_state <= S_SWEEP;
                        end else if (i_s_axis_tlast) begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_SWEEP: begin
                    if (r_j == r_tgt) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= r_last ? S_RD : S_IDLE;
                end
                S_RD: begin
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_way   <= w_over ? {ccwc_pkg::WAY_W{1'b1}}
                                            : w_cnt64[ccwc_pkg::WAY_W-1:0];
                        r_o_sat   <= w_a_sat | w_over;
                        r_j       <= '0;
                        r_state   <= S_CLEAR;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_j     <= '0;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_way;
    assign o_m_axis_tuser  = r_o_sat;

endmodule

[src/ccwc_table.sv]
// Ways table memory: two registered read ports and one write port.
module ccwc_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 33
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[src/ccwc_checker.sv]
// Port-level checker for the coin change way counter, bound to the top level.
`include "coin_change_way_counter_top_assert.svh"

module ccwc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            i_s_axis_tlast,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [ccwc_pkg::WAY_W-1:0]      o_m_axis_tdata
);

    `CCWC_ASSERT(a_out_valid_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
    `CCWC_ASSERT(a_out_data_hold, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
    `CCWC_ASSERT(a_busy_after_last, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
    `CCWC_ASSERT_ALWAYS(a_no_take_on_result, i_rst_n && $rose(o_m_axis_tvalid) |-> !o_s_axis_tready)

endmodule

bind coin_change_way_counter_top ccwc_checker u_ccwc_checker (.*);

[sim/coin_change_way_counter_top_tb.sv]
// Self-checking testbench for the coin change way counter: directed table, then random coin sets.
`timescale 1ns / 1ps

module coin_change_way_counter_top_tb;

    localparam int  COIN_W      = ccwc_pkg::COIN_W;
    localparam int  TARGET_W    = ccwc_pkg::TARGET_W;
    localparam int  IN_TDATA_W  = ccwc_pkg::IN_TDATA_W;
    localparam int  WAY_W       = ccwc_pkg::WAY_W;
    localparam int  OUT_USER_W  = ccwc_pkg::OUT_USER_W;

    localparam int  MAX_AMOUNT  = 1023;
    localparam int  TOTAL_ITEMS = 580;
    localparam int  SETTLE      = 1100;
    localparam int  HOLD_OFF    = 5000;
    localparam int  CYCLE_LIMIT = 10_000_000;
    localparam int  PLAN_ROWS   = 21;
    localparam longint unsigned COUNT_MAX = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [WAY_W-1:0] way_count;
        logic             saturated;
    } t_way_result;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [COIN_W-1:0]   coin;
        logic                last;
        logic                typed;
        logic [WAY_W-1:0]    exp_count;
        logic                exp_sat;
    } t_coin_row;

    logic                  i_clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [TARGET_W-1:0]   cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0] s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tready  = 1'b0;

    logic                  o_cfg_ready;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [WAY_W-1:0]      o_m_axis_tdata;   // [31:0] way_count
    logic [OUT_USER_W-1:0] o_m_axis_tuser;   // [0] saturated

    logic [WAY_W-1:0]      ways_tbl  [0:MAX_AMOUNT];
    bit                    sat_marks [0:MAX_AMOUNT];
    logic [TARGET_W-1:0]   target_now = '0;
    t_way_result           expected_ways [$];

    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;
    int coins_sent  = 0;
    int fail_count  = 0;
    int cycle_count = 0;

    t_coin_row coin_plan [PLAN_ROWS] = '{
        '{10'd0,    10'd0,    1'b1, 1'b1, 32'd1, 1'b0},
        '{10'd0,    10'd1023, 1'b1, 1'b1, 32'd1, 1'b0},
        '{10'd10,   10'd1,    1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd10,   10'd2,    1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd10,   10'd5,    1'b1, 1'b0, 32'd0, 1'b0},
        '{10'd5,    10'd7,    1'b1, 1'b1, 32'd0, 1'b0},
        '{10'd1023, 10'd1023, 1'b1, 1'b1, 32'd1, 1'b0},
        '{10'd1023, 10'd1,    1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd1023, 10'd0,    1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd1023, 10'd512,  1'b1, 1'b0, 32'd0, 1'b0},
        '{10'd1023, 10'd1,    1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd1023, 10'd2,    1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd1023, 10'd3,    1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd1023, 10'd4,    1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd1023, 10'd5,    1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd1023, 10'd6,    1'b1, 1'b0, 32'd0, 1'b0},
        '{10'd20,   10'd3,    1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd8,    10'd2,    1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd20,   10'd1,    1'b1, 1'b0, 32'd0, 1'b0},
        '{10'd1023, 10'd682,  1'b0, 1'b0, 32'd0, 1'b0},
        '{10'd1023, 10'd341,  1'b1, 1'b0, 32'd0, 1'b0}
    };

    coin_change_way_counter_top #(
        .MAX_AMOUNT  (MAX_AMOUNT),
        .COUNT_WIDTH (WAY_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_ways();
        for (int i = 0; i <= MAX_AMOUNT; i++) begin
            ways_tbl[i]  = '0;
            sat_marks[i] = 1'b0;
        end
        ways_tbl[0] = 1;
    endfunction

    // Apply one coin to the ways table; return 1 with the count when the set closes.
    function automatic bit sweep_coin(input logic [COIN_W-1:0] coin, input logic last,
                                      output t_way_result res);
        longint unsigned a;
        longint unsigned b;
        bit              m;
        int              t;
        t   = int'(target_now);
        res = '0;
        if (coin != 0 && int'(coin) <= t) begin
            for (int j = int'(coin); j <= t; j++) begin
                a = ways_tbl[j];
                b = ways_tbl[j - int'(coin)];
                m = sat_marks[j - int'(coin)];
                if (a > COUNT_MAX - b) begin
                    ways_tbl[j] = COUNT_MAX[WAY_W-1:0];
                    m = 1'b1;
                end else begin
                    ways_tbl[j] = WAY_W'(a + b);
                end
                sat_marks[j] = sat_marks[j] | m;
            end
        end
        if (!last)
            return 1'b0;
        res.way_count = ways_tbl[t];
        res.saturated = sat_marks[t];
        clear_ways();
        return 1'b1;
    endfunction

    function automatic logic [TARGET_W-1:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return TARGET_W'(MAX_AMOUNT);
        if (r < 5)
            return TARGET_W'($urandom_range(512, 1022));
        if (r < 15)
            return TARGET_W'($urandom_range(41, 200));
        return TARGET_W'($urandom_range(0, 40));
    endfunction

    function automatic logic [COIN_W-1:0] pick_coin(input int tgt);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 18 || tgt == 0)
            return COIN_W'($urandom_range(0, 1023));
        if (r < 60)
            return COIN_W'($urandom_range(1, (tgt < 8) ? tgt : 8));
        return COIN_W'($urandom_range(1, tgt));
    endfunction

    task automatic pause_for_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_ways.size() != 0);
    endtask

    task automatic write_target(input logic [TARGET_W-1:0] value);
        pause_for_results();
        repeat (SETTLE) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        target_now = value;
    endtask

    task automatic send_coin(input logic [COIN_W-1:0] coin, input logic last,
                             input bit typed, input t_way_result typed_res);
        int          gap;
        t_way_result res;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(coin);
        s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        coins_sent++;
        if (sweep_coin(coin, last, res))
            expected_ways.push_back(typed ? typed_res : res);
    endtask

    task automatic run_set(input bit may_reconfigure);
        int n_coins;
        n_coins = $urandom_range(1, 8);
        if (may_reconfigure && $urandom_range(0, 9) < 6)
            write_target(pick_target());
        for (int k = 0; k < n_coins; k++) begin
            if (may_reconfigure && k > 0 && $urandom_range(0, 19) == 0)
                write_target(pick_target());
            send_coin(pick_coin(int'(target_now)), k == n_coins - 1, 1'b0, '0);
        end
    endtask

    initial begin : result_sink
        int          stall;
        t_way_result want;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (m_tready && o_m_axis_tvalid) begin
                if (expected_ways.size() == 0) begin
                    $error("unexpected result: way_count %0d saturated %0d",
                           o_m_axis_tdata, o_m_axis_tuser[0]);
                    fail_count++;
                end else begin
                    want = expected_ways.pop_front();
                    if (o_m_axis_tdata !== want.way_count) begin
                        $error("way_count: expected %0d, actual %0d",
                               want.way_count, o_m_axis_tdata);
                        fail_count++;
                    end
                    if (o_m_axis_tuser[0] !== want.saturated) begin
                        $error("saturated: expected %0d, actual %0d",
                               want.saturated, o_m_axis_tuser[0]);
                        fail_count++;
                    end
                end
                stall = quiet ? 0 : $urandom_range(0, 12);
            end else if (hold_req) begin
                stall    = HOLD_OFF;
                hold_req = 1'b0;
            end else if (stall > 0) begin
                stall--;
            end
            m_tready <= (stall == 0);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int set_idx;
        clear_ways();
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (r == 0 || coin_plan[r].target != target_now)
                write_target(coin_plan[r].target);
            send_coin(coin_plan[r].coin, coin_plan[r].last, coin_plan[r].typed,
                      t_way_result'{coin_plan[r].exp_count, coin_plan[r].exp_sat});
        end

        set_idx = 0;
        while (coins_sent < TOTAL_ITEMS) begin
            quiet = ($urandom_range(0, 4) == 0);
            if (set_idx == 4 || set_idx == 45) begin
                // stall the output while several sets keep arriving
                hold_req = 1'b1;
                repeat (3) run_set(1'b0);
            end else if (set_idx == 30) begin
                pause_for_results();
                run_set(1'b1);
            end else begin
                run_set(1'b1);
            end
            set_idx++;
        end

        pause_for_results();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/ccwc_pkg.sv
src/ccwc_table.sv
src/coin_change_way_counter_top.sv
src/ccwc_checker.sv
sim/coin_change_way_counter_top_tb.sv
